FILE: rtl/core/sbfd_pkg.sv
package sbfd_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN   = 25;
    localparam int unsigned STORE_BYTES = 12;   // header plus the 11 channel bytes
    localparam int unsigned CHAN_NUM    = 8;
    localparam int unsigned RAW_W       = 11;
    localparam int unsigned CHAN_W      = 12;
    localparam int unsigned KEY_W       = 10;
    localparam int unsigned COUNT_W     = 5;

    localparam logic [7:0]         HDR_BYTE  = 8'h0f;
    localparam logic [7:0]         END_BYTE  = 8'h00;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [COUNT_W-1:0] COUNT_LEN = 5'(FRAME_LEN);
    localparam logic [COUNT_W-1:0] COUNT_END = 5'(FRAME_LEN - 1);
    localparam logic [COUNT_W-1:0] COUNT_STO = 5'(STORE_BYTES);

    // Key bit positions
    localparam int unsigned KEY_A_UP   = 0;
    localparam int unsigned KEY_A_DOWN = 1;
    localparam int unsigned KEY_A_MID  = 2;
    localparam int unsigned KEY_B_UP   = 3;
    localparam int unsigned KEY_B_DOWN = 4;
    localparam int unsigned KEY_C_UP   = 5;
    localparam int unsigned KEY_C_DOWN = 6;
    localparam int unsigned KEY_D_UP   = 7;
    localparam int unsigned KEY_D_DOWN = 8;
    localparam int unsigned KEY_D_MID  = 9;

    // Register map
    typedef enum logic [1:0] {
        CFG_CHAN_OFFSET = 2'd0,
        CFG_LOW_LIMIT   = 2'd1,
        CFG_HIGH_LIMIT  = 2'd2,
        CFG_DEADZONE    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        [10:0] chan_offset;
        logic signed [11:0] low_limit;
        logic signed [11:0] high_limit;
        logic        [9:0]  deadzone;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        chan_offset: 11'd1024,
        low_limit:   -12'sd672,
        high_limit:  12'sd672,
        deadzone:    10'd50
    };

    // Switch position
    typedef enum logic [1:0] {
        SW_UP   = 2'd0,
        SW_MID  = 2'd1,
        SW_DOWN = 2'd2
    } t_sw_pos;

    typedef struct packed {
        t_sw_pos a;
        t_sw_pos b;
        t_sw_pos c;
        t_sw_pos d;
    } t_sw_state;

    typedef logic [STORE_BYTES-1:0][7:0] t_frame_bytes;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_idle;
    } t_in_item;

    typedef struct packed {
        logic signed [CHAN_W-1:0] chan_0;
        logic signed [CHAN_W-1:0] chan_1;
        logic signed [CHAN_W-1:0] chan_2;
        logic signed [CHAN_W-1:0] chan_3;
        logic signed [CHAN_W-1:0] chan_4;
        logic signed [CHAN_W-1:0] chan_5;
        logic signed [CHAN_W-1:0] chan_6;
        logic signed [CHAN_W-1:0] chan_7;
        logic        [KEY_W-1:0]  key_flags;
    } t_out_item;

endpackage

FILE: rtl/core/sbfd_decode.sv
module sbfd_decode
    import sbfd_pkg::*;
(
    input  t_frame_bytes i_frame,
    input  logic [7:0]   i_last_byte,
    input  t_cfg         i_cfg,
    input  t_sw_state    i_prev,
    output logic         o_frame_ok,
    output t_out_item    o_item,
    output t_sw_state    o_next
);

    logic [8*(STORE_BYTES-1)-1:0]    payload;
    logic signed [CHAN_W-1:0]        chan [CHAN_NUM];
    logic signed [CHAN_W:0]          lo_thr;
    logic signed [CHAN_W:0]          hi_thr;
    t_sw_pos                         pos [4];
    logic [KEY_W-1:0]                keys;

    function automatic t_sw_pos classify(
        input logic signed [CHAN_W-1:0] v,
        input logic signed [CHAN_W:0]   lo,
        input logic signed [CHAN_W:0]   hi
    );
        logic signed [CHAN_W:0] vx;
        vx = {v[CHAN_W-1], v};
        if (vx <= lo) begin
            return SW_UP;
        end else if (vx >= hi) begin
            return SW_DOWN;
        end
        return SW_MID;
    endfunction

    // Header and end marker
    assign o_frame_ok = (i_frame[0] == HDR_BYTE) && (i_last_byte == END_BYTE);

    // Channel bits are packed LSB first from byte 1 on
    always_comb begin
        for (int b = 1; b < STORE_BYTES; b++) begin
            payload[8*(b-1) +: 8] = i_frame[b];
        end
    end

    // Unpack and remove offset
    always_comb begin
        for (int i = 0; i < CHAN_NUM; i++) begin
            chan[i] = $signed({1'b0, payload[RAW_W*i +: RAW_W]})
                    - $signed({1'b0, i_cfg.chan_offset});
        end
    end

    // Switch thresholds, limits widened by one bit
    assign lo_thr = $signed({i_cfg.low_limit[CHAN_W-1], i_cfg.low_limit})
                  + $signed({3'b000, i_cfg.deadzone});
    assign hi_thr = $signed({i_cfg.high_limit[CHAN_W-1], i_cfg.high_limit})
                  - $signed({3'b000, i_cfg.deadzone});

    always_comb begin
        for (int s = 0; s < 4; s++) begin
            pos[s] = classify(chan[4+s], lo_thr, hi_thr);
        end
    end

    // Key events from previous and new positions
    always_comb begin
        keys = '0;
        priority if (i_prev.a == SW_MID && pos[0] == SW_UP) begin
            keys[KEY_A_UP] = 1'b1;
        end else if (i_prev.a == SW_MID && pos[0] == SW_DOWN) begin
            keys[KEY_A_DOWN] = 1'b1;
        end else if (pos[0] == SW_MID) begin
            keys[KEY_A_MID] = 1'b1;
        end
        priority if (i_prev.b == SW_DOWN && pos[1] == SW_UP) begin
            keys[KEY_B_UP] = 1'b1;
        end else if (i_prev.b == SW_UP && pos[1] == SW_DOWN) begin
            keys[KEY_B_DOWN] = 1'b1;
        end
        priority if (i_prev.c == SW_DOWN && pos[2] == SW_UP) begin
            keys[KEY_C_UP] = 1'b1;
        end else if (i_prev.c == SW_UP && pos[2] == SW_DOWN) begin
            keys[KEY_C_DOWN] = 1'b1;
        end
        priority if (i_prev.d == SW_MID && pos[3] == SW_UP) begin
            keys[KEY_D_UP] = 1'b1;
        end else if (i_prev.d == SW_MID && pos[3] == SW_DOWN) begin
            keys[KEY_D_DOWN] = 1'b1;
        end else if (pos[3] == SW_MID) begin
            keys[KEY_D_MID] = 1'b1;
        end
    end

    assign o_next = '{a: pos[0], b: pos[1], c: pos[2], d: pos[3]};

    assign o_item = '{
        chan_0:    chan[0],
        chan_1:    chan[1],
        chan_2:    chan[2],
        chan_3:    chan[3],
        chan_4:    chan[4],
        chan_5:    chan[5],
        chan_6:    chan[6],
        chan_7:    chan[7],
        key_flags: keys
    };

endmodule

FILE: rtl/core/sbfd_frame_decoder_switch_events_core.sv
// Serial frame decoder with switch key events. Each input item is one
// received byte, or a line-idle marker that closes the frame. Bytes are
// counted (saturating at 31) and the header and channel bytes kept in
// registers. At idle, a frame of exactly 25 bytes with header 0x0f and
// last byte 0x00 gives one result item: eight 12-bit signed channels
// (raw minus channel_offset) and a ten-bit key mask built from the old
// and new positions of switches A to D. Any other frame gives nothing
// and leaves the switch positions alone. One item is taken every cycle;
// the decode is a single combinational pass from the byte registers into
// the output register, so a result shows in the cycle after its idle item.
// Input stalls only while a finished result sits stalled at the output.
// Configuration is written over the APB port at byte addresses 0, 4, 8, 12.
module sbus_frame_decoder_switch_events_core
    import sbfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg               r_cfg;
    t_frame_bytes       r_frame;
    logic [7:0]         r_last_byte;
    logic [COUNT_W-1:0] r_count;
    t_sw_state          r_sw;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               in_accept;
    logic               cfg_write;
    t_cfg_idx           cfg_idx;
    logic               frame_ok;
    logic               emit;
    t_out_item          dec_item;
    t_sw_state          dec_next;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign pready     = 1'b1;
    assign cfg_write  = psel & penable & pwrite & pready;
    assign cfg_idx    = t_cfg_idx'(paddr[3:2]);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                CFG_CHAN_OFFSET: r_cfg.chan_offset <= pwdata[10:0];
                CFG_LOW_LIMIT:   r_cfg.low_limit   <= $signed(pwdata[11:0]);
                CFG_HIGH_LIMIT:  r_cfg.high_limit  <= $signed(pwdata[11:0]);
                CFG_DEADZONE:    r_cfg.deadzone    <= pwdata[9:0];
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            CFG_CHAN_OFFSET: prdata = {21'b0, r_cfg.chan_offset};
            CFG_LOW_LIMIT:   prdata = {20'b0, r_cfg.low_limit};
            CFG_HIGH_LIMIT:  prdata = {20'b0, r_cfg.high_limit};
            CFG_DEADZONE:    prdata = {22'b0, r_cfg.deadzone};
        endcase
    end

    // Byte store: header and channel bytes, plus the last byte
    always_ff @(posedge i_clk) begin
        if (in_accept && !i_in_item.line_idle) begin
            if (r_count < COUNT_STO) begin
                r_frame[r_count[3:0]] <= i_in_item.rx_byte;
            end
            if (r_count == COUNT_END) begin
                r_last_byte <= i_in_item.rx_byte;
            end
        end
    end

    // Byte counter, saturating; cleared on idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_accept) begin
            if (i_in_item.line_idle) begin
                r_count <= '0;
            end else if (r_count < COUNT_MAX) begin
                r_count <= r_count + 5'd1;
            end
        end
    end

    sbfd_decode u_decode (
        .i_frame     (r_frame),
        .i_last_byte (r_last_byte),
        .i_cfg       (r_cfg),
        .i_prev      (r_sw),
        .o_frame_ok  (frame_ok),
        .o_item      (dec_item),
        .o_next      (dec_next)
    );

    assign emit = in_accept && i_in_item.line_idle && (r_count == COUNT_LEN) && frame_ok;

    // Switch positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= '{a: SW_MID, b: SW_DOWN, c: SW_DOWN, d: SW_MID};
        end else if (emit) begin
            r_sw <= dec_next;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item <= dec_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
